FILE: rtl/core/button_press_classifier_macros.svh
// assertion macros for the button press classifier
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define BPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define BPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

    localparam logic [15:0] SAT16 = 16'hFFFF;

    localparam logic [2:0] CFG_DEBOUNCE_TIME   = 3'd0;
    localparam logic [2:0] CFG_SHORT_MIN_TIME  = 3'd1;
    localparam logic [2:0] CFG_GRACE_TIME      = 3'd2;
    localparam logic [2:0] CFG_ACTIVE_LEVEL    = 3'd3;
    localparam logic [2:0] CFG_RAW_EDGE_ENABLE = 3'd4;

    localparam logic [15:0] RST_DEBOUNCE_TIME  = 16'd20;
    localparam logic [15:0] RST_SHORT_MIN_TIME = 16'd50;
    localparam logic [15:0] RST_GRACE_TIME     = 16'd2000;

    typedef enum logic [1:0] {
        EV_SHORT      = 2'd0,
        EV_LONG       = 2'd1,
        EV_ASSERTED   = 2'd2,
        EV_DEASSERTED = 2'd3
    } t_event_kind;

    typedef enum logic [1:0] {
        RS_RELEASE = 2'd0,
        RS_HOLD    = 2'd1,
        RS_FALLING = 2'd2,
        RS_RISING  = 2'd3
    } t_event_reason;

    typedef struct packed {
        logic          event_valid;
        t_event_kind   event_kind;
        t_event_reason event_reason;
        logic [31:0]   event_time;
        logic [15:0]   event_arg;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/bpc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bpc_poll_if;
    logic        valid;
    logic        ready;
    logic [31:0] time_now;
    logic        pin_level;

    modport source (output valid, output time_now, output pin_level, input ready);
    modport sink   (input valid, input time_now, input pin_level, output ready);
endinterface

interface bpc_result_if;
    logic        valid;
    logic        ready;
    logic        event_valid;
    logic [1:0]  event_kind;
    logic [1:0]  event_reason;
    logic [31:0] event_time;
    logic [15:0] event_arg;
    logic        pressed_now;
    logic [15:0] last_duration;
    logic        last_of_run;

    modport source (
        output valid, output event_valid, output event_kind, output event_reason,
        output event_time, output event_arg, output pressed_now,
        output last_duration, output last_of_run, input ready
    );
    modport sink (
        input valid, input event_valid, input event_kind, input event_reason,
        input event_time, input event_arg, input pressed_now,
        input last_duration, input last_of_run, output ready
    );
endinterface

interface bpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/button_press_classifier.sv
`timescale 1ns / 1ps
`default_nettype none

// Debounced button press classifier. Each poll transaction (time_now in ms,
// sampled pin_level) is held in an input register and classified by
// single-pass logic into one or two result transactions in the output register:
// an optional raw edge event, a short or long press event, or a status-only
// result; every result carries pressed_now, last_duration and last_of_run.
// A poll enters every cycle while the output side keeps up; the output register
// hands out one result per cycle while ready is high, so a poll giving two results
// holds it until both are taken. Configuration writes are always ready and take
// effect the next cycle; write only while idle.

`include "button_press_classifier_macros.svh"

module button_press_classifier (
    input  wire            i_clk,
    input  wire            i_rst_n,
    bpc_cfg_if.sink        i_cfg,
    bpc_poll_if.sink       i_poll,
    bpc_result_if.source   o_result
);

    // configuration
    logic [15:0] r_debounce_time;
    logic [15:0] r_short_min_time;
    logic [15:0] r_grace_time;
    logic        r_active_level;
    logic        r_raw_edge_enable;

    // tracking state
    logic        r_stable_level;
    logic [31:0] r_last_edge_time;
    logic        r_press_active;
    logic [31:0] r_press_start;
    logic        r_long_sent;
    logic [15:0] r_last_len;

    // input register
    logic        r_in_valid;
    logic [31:0] r_in_time;
    logic        r_in_level;

    // output register
    bpc_pkg::t_result r_res [2];
    logic        r_out_pressed;
    logic [15:0] r_out_last_len;
    logic [1:0]  r_cnt;
    logic        r_rd;

    logic        out_fire;
    logic        out_last;
    logic        out_free;
    logic        advance;

    logic [31:0] edge_diff;
    logic        change;
    logic        asserted;
    logic [31:0] held;
    logic [15:0] held_sat;
    logic [31:0] hold_held;
    logic [15:0] hold_sat;
    logic        release_evt;
    logic        hold_evt;

    bpc_pkg::t_result raw_res;
    bpc_pkg::t_result press_res;
    bpc_pkg::t_result n_res [2];
    logic [1:0]  n_cnt;

    logic        n_stable_level;
    logic [31:0] n_last_edge_time;
    logic        n_press_active;
    logic [31:0] n_press_start;
    logic        n_long_sent;
    logic [15:0] n_last_len;

    // handshakes
    assign i_cfg.ready  = 1'b1;
    assign out_last     = (r_cnt == 2'd1) || r_rd;
    assign out_fire     = o_result.valid && o_result.ready;
    assign out_free     = (r_cnt == 2'd0) || (out_fire && out_last);
    assign advance      = r_in_valid && out_free;
    assign i_poll.ready = !r_in_valid || out_free;

    // classification
    always_comb begin
        edge_diff = r_in_time - r_last_edge_time;
        change    = (r_in_level != r_stable_level) && (edge_diff >= {16'h0, r_debounce_time});
        asserted  = (r_in_level == r_active_level);
        held      = r_in_time - r_press_start;
        held_sat  = (|held[31:16]) ? bpc_pkg::SAT16 : held[15:0];
        hold_held = (change && asserted) ? 32'h0 : held;
        hold_sat  = (|hold_held[31:16]) ? bpc_pkg::SAT16 : hold_held[15:0];

        n_stable_level   = r_stable_level;
        n_last_edge_time = r_last_edge_time;
        n_press_active   = r_press_active;
        n_press_start    = r_press_start;
        n_long_sent      = r_long_sent;
        n_last_len       = r_last_len;

        raw_res.event_valid  = change && r_raw_edge_enable;
        raw_res.event_kind   = asserted ? bpc_pkg::EV_ASSERTED : bpc_pkg::EV_DEASSERTED;
        raw_res.event_reason = asserted ? bpc_pkg::RS_FALLING : bpc_pkg::RS_RISING;
        raw_res.event_time   = r_in_time;
        raw_res.event_arg    = {15'h0, r_in_level};

        press_res.event_valid  = 1'b0;
        press_res.event_kind   = bpc_pkg::EV_SHORT;
        press_res.event_reason = bpc_pkg::RS_RELEASE;
        press_res.event_time   = r_in_time;
        press_res.event_arg    = held_sat;

        release_evt = 1'b0;
        if (change) begin
            n_last_edge_time = r_in_time;
            n_stable_level   = r_in_level;
            if (asserted) begin
                n_press_active = 1'b1;
                n_press_start  = r_in_time;
                n_long_sent    = 1'b0;
            end else begin
                if (r_press_active) begin
                    n_last_len  = held_sat;
                    release_evt = !r_long_sent;
                end
                n_press_active = 1'b0;
                n_press_start  = 32'h0;
                n_long_sent    = 1'b0;
            end
        end

        if (release_evt) begin
            if (held_sat >= r_grace_time) begin
                press_res.event_valid = 1'b1;
                press_res.event_kind  = bpc_pkg::EV_LONG;
            end else if (held_sat >= r_short_min_time) begin
                press_res.event_valid = 1'b1;
            end
        end

        // hold timeout, never together with a release
        hold_evt = n_press_active && !n_long_sent && (hold_held >= {16'h0, r_grace_time});
        if (hold_evt) begin
            n_long_sent            = 1'b1;
            press_res.event_valid  = 1'b1;
            press_res.event_kind   = bpc_pkg::EV_LONG;
            press_res.event_reason = bpc_pkg::RS_HOLD;
            press_res.event_arg    = hold_sat;
        end

        n_res[1] = press_res;
        if (raw_res.event_valid) begin
            n_res[0] = raw_res;
            n_cnt    = press_res.event_valid ? 2'd2 : 2'd1;
        end else if (press_res.event_valid) begin
            n_res[0] = press_res;
            n_cnt    = 2'd1;
        end else begin
            n_res[0] = '0;
            n_cnt    = 2'd1;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_time   <= bpc_pkg::RST_DEBOUNCE_TIME;
            r_short_min_time  <= bpc_pkg::RST_SHORT_MIN_TIME;
            r_grace_time      <= bpc_pkg::RST_GRACE_TIME;
            r_active_level    <= 1'b0;
            r_raw_edge_enable <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bpc_pkg::CFG_DEBOUNCE_TIME:   r_debounce_time   <= i_cfg.data;
                bpc_pkg::CFG_SHORT_MIN_TIME:  r_short_min_time  <= i_cfg.data;
                bpc_pkg::CFG_GRACE_TIME:      r_grace_time      <= i_cfg.data;
                bpc_pkg::CFG_ACTIVE_LEVEL:    r_active_level    <= i_cfg.data[0];
                bpc_pkg::CFG_RAW_EDGE_ENABLE: r_raw_edge_enable <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // tracking state, updated as a poll moves to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_level   <= 1'b1;
            r_last_edge_time <= 32'h0;
            r_press_active   <= 1'b0;
            r_press_start    <= 32'h0;
            r_long_sent      <= 1'b0;
            r_last_len       <= 16'h0;
        end else if (advance) begin
            r_stable_level   <= n_stable_level;
            r_last_edge_time <= n_last_edge_time;
            r_press_active   <= n_press_active;
            r_press_start    <= n_press_start;
            r_long_sent      <= n_long_sent;
            r_last_len       <= n_last_len;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_poll.ready) begin
            r_in_valid <= i_poll.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_poll.valid && i_poll.ready) begin
            r_in_time  <= i_poll.time_now;
            r_in_level <= i_poll.pin_level;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else if (advance) begin
            r_cnt <= n_cnt;
            r_rd  <= 1'b0;
        end else if (out_fire) begin
            if (out_last) begin
                r_cnt <= 2'd0;
                r_rd  <= 1'b0;
            end else begin
                r_rd <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res[0]       <= n_res[0];
            r_res[1]       <= n_res[1];
            r_out_pressed  <= n_press_active;
            r_out_last_len <= n_last_len;
        end
    end

    assign o_result.valid         = (r_cnt != 2'd0);
    assign o_result.event_valid   = r_res[r_rd].event_valid;
    assign o_result.event_kind    = r_res[r_rd].event_kind;
    assign o_result.event_reason  = r_res[r_rd].event_reason;
    assign o_result.event_time    = r_res[r_rd].event_time;
    assign o_result.event_arg     = r_res[r_rd].event_arg;
    assign o_result.pressed_now   = r_out_pressed;
    assign o_result.last_duration = r_out_last_len;
    assign o_result.last_of_run   = out_last;

    // checks
    `BPC_ASSERT_IMP(a_rd_in_range, i_clk, i_rst_n, r_rd, r_cnt == 2'd2, "read slot beyond count")
    `BPC_ASSERT_IMP(a_long_needs_press, i_clk, i_rst_n, !r_press_active,
        !r_long_sent && (r_press_start == 32'h0), "long flag or start time without a press")
    `BPC_ASSERT_IMP(a_pair_both_events, i_clk, i_rst_n, r_cnt == 2'd2,
        r_res[0].event_valid && r_res[1].event_valid, "two results without two events")
    `BPC_ASSERT_NXT(a_edge_time_taken, i_clk, i_rst_n, advance && change,
        r_last_edge_time == $past(r_in_time), "accepted change did not record its time")

endmodule

`default_nettype wire
